>>> design/page_frame_victim_select_top_defines.svh
// Assertion macros shared by the frame selector
`ifndef PAGE_FRAME_VICTIM_SELECT_TOP_DEFINES_SVH
`define PAGE_FRAME_VICTIM_SELECT_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PFVS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfvs check failed");
// implication checked in the next cycle
`define PFVS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfvs check failed");
`endif

>>> design/pfvs_pkg.sv
// ----------------------------------------------------------------------------
// pfvs_pkg
// Types and constants of the page frame victim selector.
// ----------------------------------------------------------------------------
`default_nettype none
package pfvs_pkg;
	localparam int FRAME_COUNT_DEF = 64;
	localparam int STAMP_BITS_DEF  = 32;
	localparam int IDX_W           = 6;
	localparam int IN_STAMP_W      = 32;

	typedef enum logic [1:0] {
		POL_RANDOM = 2'd0,
		POL_OLDEST = 2'd1,
		POL_CLOCK  = 2'd2,
		POL_NONE   = 2'd3
	} policy_t;

	typedef enum logic [1:0] {
		ST_WRITE = 2'd0,
		ST_FRAME = 2'd1,
		ST_NONE  = 2'd2
	} status_t;

	localparam logic FUNC_WRITE = 1'b0;

	// cell control: one broadcast per cycle to every cell
	typedef struct packed {
		logic rotate;       // shift ring by one toward the head
		logic wr_en;        // write entry at absolute index
		logic clr_head;     // clear stamp of head frame as it wraps to the tail
		logic unmap_en;     // clear mapped bit at absolute index
	} cell_ctrl_t;
endpackage
`default_nettype wire

>>> design/page_frame_victim_select_top.sv
// ----------------------------------------------------------------------------
// page_frame_victim_select_top
// Frame table with victim selection under random, FIFO or clock policy.
// ----------------------------------------------------------------------------
// Channels: s_axis (tvalid/tready/tdata) takes one word per item; tuser
// carries func (0 write entry, 1 select). m_axis returns one result word per
// item. cfg (valid/ready/data) writes the policy register while idle.
// The table sits in a ring of cells that rotates one place per cycle in a
// scan, so the head cell is the only one the sequencer reads; frame 0 is at
// the head when idle. A write goes straight to the output register. A select
// scans the ring for a free frame, then unmaps the victim and posts the
// result. With no free frame, random or oldest first add a second pass over
// the ring; the clock sweep turns to the hand, visits up to 2*FRAME_COUNT
// frames and turns back to frame 0.
// One item is in flight at a time; s_tready is low until the result is taken,
// so the next word is accepted in the cycle after that at the earliest.
// Reset clears the table, hand and policy at once; no clearing pass.
// When m_tready is low the result holds in its register and input stalls.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_frame_victim_select_top_defines.svh"
module page_frame_victim_select_top #(
	parameter int FRAME_COUNT = pfvs_pkg::FRAME_COUNT_DEF,
	parameter int STAMP_BITS  = pfvs_pkg::STAMP_BITS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// [5:0] frame_index, [6] prot_in, [7] mapped_in, [39:8] stamp_in,
	// [71:40] now, [135:72] coin_bits
	input  wire  [135:0] s_tdata,
	input  wire          s_tuser,      // [0] func
	output logic         m_tvalid,
	input  wire          m_tready,
	// [5:0] victim, [6] was_mapped, [8:7] status, rest zero
	output logic [15:0]  m_tdata,
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [1:0]   cfg_data
);
	import pfvs_pkg::*;

	localparam int IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

	policy_t                policy_q;
	cell_ctrl_t             ctrl;
	logic                   busy;
	logic [IW-1:0]          base, wr_abs, unmap_abs;
	logic                   res_valid, res_map;
	logic [IDX_W-1:0]       res_victim;
	status_t                res_status;
	logic [STAMP_BITS-1:0]  wr_stamp, now_w;
	logic [IN_STAMP_W-1:0]  stamp_raw, now_raw;
	logic [FRAME_COUNT-1:0] p, m;
	logic [STAMP_BITS-1:0]  st [FRAME_COUNT];
	logic                   s_acc;

	assign s_tready  = !busy;
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = !busy;
	assign stamp_raw = s_tdata[39:8];
	assign now_raw   = s_tdata[71:40];
	assign wr_stamp  = STAMP_BITS'(stamp_raw);
	assign now_w     = STAMP_BITS'(now_raw);
	assign m_tvalid  = res_valid;
	assign m_tdata   = {7'd0, res_status, res_map, res_victim};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			policy_q <= POL_RANDOM;
		else if (cfg_valid && cfg_ready)
			policy_q <= policy_t'(cfg_data);
	end

	// cell j holds frame (base + j) mod FRAME_COUNT; cell 0 is the head
	for (genvar j = 0; j < FRAME_COUNT; j++) begin : g_cell
		logic [IW:0]   sum;
		logic [IW-1:0] abs_idx;
		assign sum     = {1'b0, base} + (IW+1)'(j);
		assign abs_idx = (sum >= (IW+1)'(FRAME_COUNT)) ?
			IW'(sum - (IW+1)'(FRAME_COUNT)) : sum[IW-1:0];
		pfvs_cell #(.STAMP_BITS(STAMP_BITS)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.sel_wr   (abs_idx == wr_abs),
			.sel_unmap(abs_idx == unmap_abs),
			.is_tail  (j == FRAME_COUNT - 1),
			.wr_prot  (s_tdata[6]),
			.wr_map   (s_tdata[7]),
			.wr_stamp (wr_stamp),
			.nb_prot  (p[(j + 1) % FRAME_COUNT]),
			.nb_map   (m[(j + 1) % FRAME_COUNT]),
			.nb_stamp (st[(j + 1) % FRAME_COUNT]),
			.prot     (p[j]),
			.map      (m[j]),
			.stamp    (st[j])
		);
	end

	pfvs_ctrl #(.FRAME_COUNT(FRAME_COUNT), .STAMP_BITS(STAMP_BITS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.policy     (policy_q),
		.start      (s_acc),
		.func       (s_tuser),
		.frame_index(s_tdata[5:0]),
		.now        (now_w),
		.coin_bits  (s_tdata[135:72]),
		.out_free   (m_tready),
		.head_prot  (p[0]),
		.head_map   (m[0]),
		.head_stamp (st[0]),
		.busy       (busy),
		.ctrl       (ctrl),
		.base       (base),
		.wr_abs     (wr_abs),
		.unmap_abs  (unmap_abs),
		.res_valid  (res_valid),
		.res_victim (res_victim),
		.res_map    (res_map),
		.res_status (res_status)
	);

	`PFVS_ASSERT_IMP(a_no_accept_busy, m_tvalid, !s_tready)
	`PFVS_ASSERT_IMP(a_none_zero, m_tvalid && res_status == ST_NONE,
		res_victim == '0 && !res_map)
	`PFVS_ASSERT_NEXT(a_write_quick, s_acc && !s_tuser, m_tvalid && res_status == ST_WRITE)
endmodule
`default_nettype wire

>>> design/pfvs_cell.sv
// ----------------------------------------------------------------------------
// pfvs_cell
// One frame entry of the rotating ring: protected bit, mapped bit, stamp.
// ----------------------------------------------------------------------------
`default_nettype none
module pfvs_cell #(
	parameter int STAMP_BITS = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  pfvs_pkg::cell_ctrl_t  ctrl,
	input  wire                   sel_wr,
	input  wire                   sel_unmap,
	input  wire                   is_tail,
	input  wire                   wr_prot,
	input  wire                   wr_map,
	input  wire  [STAMP_BITS-1:0] wr_stamp,
	input  wire                   nb_prot,
	input  wire                   nb_map,
	input  wire  [STAMP_BITS-1:0] nb_stamp,
	output logic                  prot,
	output logic                  map,
	output logic [STAMP_BITS-1:0] stamp
);
	import pfvs_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prot  <= 1'b0;
			map   <= 1'b0;
			stamp <= '0;
		end else if (ctrl.rotate) begin
			prot  <= nb_prot;
			map   <= nb_map;
			// the tail takes the old head; drop its stamp when the sweep passes it
			stamp <= (ctrl.clr_head && is_tail) ? '0 : nb_stamp;
		end else begin
			if (ctrl.wr_en && sel_wr) begin
				prot  <= wr_prot;
				map   <= wr_map;
				stamp <= wr_stamp;
			end
			if (ctrl.unmap_en && sel_unmap)
				map <= 1'b0;
		end
	end
endmodule
`default_nettype wire

>>> design/pfvs_ctrl.sv
// ----------------------------------------------------------------------------
// pfvs_ctrl
// Sequencer: walks the ring one frame a cycle and picks the victim.
// ----------------------------------------------------------------------------
`default_nettype none
module pfvs_ctrl #(
	parameter int FRAME_COUNT = 64,
	parameter int STAMP_BITS  = 32,
	localparam int IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  pfvs_pkg::policy_t            policy,
	input  wire                          start,
	input  wire                          func,
	input  wire  [pfvs_pkg::IDX_W-1:0]   frame_index,
	input  wire  [STAMP_BITS-1:0]        now,
	input  wire  [63:0]                  coin_bits,
	input  wire                          out_free,
	input  wire                          head_prot,
	input  wire                          head_map,
	input  wire  [STAMP_BITS-1:0]        head_stamp,
	output logic                         busy,
	output pfvs_pkg::cell_ctrl_t         ctrl,
	output logic [IW-1:0]                base,
	output logic [IW-1:0]                wr_abs,
	output logic [IW-1:0]                unmap_abs,
	output logic                         res_valid,
	output logic [pfvs_pkg::IDX_W-1:0]   res_victim,
	output logic                         res_map,
	output pfvs_pkg::status_t            res_status
);
	import pfvs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_FREE, S_POL, S_SEEK, S_CLOCK, S_HOME, S_DONE, S_UNMAP
	} state_t;

	state_t                state_q;
	logic [IW:0]           cnt_q;     // frames visited in this pass
	logic [IW-1:0]         base_q;    // absolute index held by the head cell
	logic [IW-1:0]         hand_q;
	logic [STAMP_BITS-1:0] now_q;
	logic [63:0]           coin_q;
	logic [5:0]            k_q;
	logic                  found_q;
	logic [IW-1:0]         best_q;
	logic [STAMP_BITS-1:0] best_age_q;
	logic                  best_map_q;
	logic                  done_q;    // random: coin hit seen
	logic                  out_pend_q;

	logic [STAMP_BITS-1:0] age;
	logic [IW:0]           clk_lim;
	logic                  last_visit;
	logic [IW-1:0]         base_nx;
	logic                  clk_take;

	assign age        = now_q - head_stamp;
	assign base_nx    = (base_q == IW'(FRAME_COUNT - 1)) ? '0 : base_q + 1'b1;
	assign last_visit = (cnt_q == (IW+1)'(FRAME_COUNT - 1));
	assign clk_lim    = (IW+1)'(FRAME_COUNT - 1);
	assign clk_take   = !head_prot && (head_stamp == '0);

	assign busy      = (state_q != S_IDLE) || out_pend_q;
	assign base      = base_q;
	assign wr_abs    = frame_index[IW-1:0];
	assign unmap_abs = best_q;

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			S_IDLE:  ctrl.wr_en = start && (func == FUNC_WRITE) &&
				({1'b0, frame_index} < (IDX_W+1)'(FRAME_COUNT)) && !out_pend_q;
			S_FREE, S_POL: ctrl.rotate = 1'b1;
			S_SEEK:  ctrl.rotate = (base_q != hand_q);
			S_CLOCK: begin
				ctrl.rotate   = 1'b1;
				ctrl.clr_head = !clk_take;
			end
			S_HOME:  ctrl.rotate = (base_q != '0);
			S_UNMAP: ctrl.unmap_en = found_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			base_q     <= '0;
			hand_q     <= '0;
			now_q      <= '0;
			coin_q     <= '0;
			k_q        <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			best_age_q <= '0;
			best_map_q <= 1'b0;
			done_q     <= 1'b0;
			out_pend_q <= 1'b0;
			res_valid  <= 1'b0;
			res_victim <= '0;
			res_map    <= 1'b0;
			res_status <= ST_WRITE;
		end else begin
			if (res_valid && out_free) begin
				res_valid  <= 1'b0;
				out_pend_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start && !out_pend_q) begin
						now_q      <= now;
						coin_q     <= coin_bits;
						k_q        <= '0;
						cnt_q      <= '0;
						found_q    <= 1'b0;
						done_q     <= 1'b0;
						best_age_q <= '0;
						best_q     <= '0;
						best_map_q <= 1'b0;
						if (func == FUNC_WRITE) begin
							res_valid  <= 1'b1;
							out_pend_q <= 1'b1;
							res_victim <= '0;
							res_map    <= 1'b0;
							res_status <= ST_WRITE;
						end else
							state_q <= S_FREE;
					end
				end
				S_FREE: begin
					// ring rotates; head holds frame base_q
					if (!found_q && !head_prot && !head_map) begin
						found_q <= 1'b1;
						best_q  <= base_q;
						best_map_q <= 1'b0;
					end
					base_q <= base_nx;
					cnt_q  <= cnt_q + 1'b1;
					if (last_visit) begin
						cnt_q <= '0;
						if (found_q || (!head_prot && !head_map))
							state_q <= S_DONE;
						else if (policy == POL_CLOCK)
							state_q <= S_SEEK;
						else if (policy == POL_NONE)
							state_q <= S_DONE;
						else
							state_q <= S_POL;
					end
				end
				S_POL: begin
					if (!head_prot) begin
						if (policy == POL_RANDOM) begin
							if (!done_q) begin
								found_q    <= 1'b1;
								best_q     <= base_q;
								best_map_q <= head_map;
								if (coin_q[k_q]) done_q <= 1'b1;
								k_q <= k_q + 1'b1;
							end
						end else if (!found_q || age > best_age_q) begin
							found_q    <= 1'b1;
							best_q     <= base_q;
							best_map_q <= head_map;
							best_age_q <= age;
						end
					end
					base_q <= base_nx;
					cnt_q  <= cnt_q + 1'b1;
					if (last_visit)
						state_q <= S_DONE;
				end
				S_SEEK: begin
					// rotate until the head holds the hand's frame
					if (base_q == hand_q)
						state_q <= S_CLOCK;
					else
						base_q <= base_nx;
				end
				S_CLOCK: begin
					base_q <= base_nx;
					hand_q <= base_nx;
					if (clk_take) begin
						found_q    <= 1'b1;
						best_q     <= base_q;
						best_map_q <= head_map;
						state_q    <= S_HOME;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == {clk_lim[IW-1:0], 1'b1})
							state_q <= S_HOME;
					end
				end
				S_HOME: begin
					// bring frame 0 back to the head
					if (base_q == '0)
						state_q <= S_DONE;
					else
						base_q <= base_nx;
				end
				S_DONE: state_q <= S_UNMAP;
				S_UNMAP: begin
					res_valid  <= 1'b1;
					out_pend_q <= 1'b1;
					res_victim <= IDX_W'(best_q);
					res_map    <= found_q ? best_map_q : 1'b0;
					res_status <= found_q ? ST_FRAME : ST_NONE;
					if (!found_q) begin
						res_victim <= '0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
